>>> rtl/core/spa_pkg.sv
// ----------------------------------------------------------------------------
// Slot pool allocator package
// Shared types, codes and widths for the slot pool allocator.
// ----------------------------------------------------------------------------
package spa_pkg;

  // Payload widths fixed by the item formats.
  localparam int unsigned SLOT_IDX_W   = 7;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned ADDR_W       = 64;
  localparam int unsigned BASE_W       = 48;
  localparam int unsigned SLOT_BYTES_W = 13;

  // Configuration port widths.
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 48;

  // Bitmap scan chunk width.
  localparam int unsigned CHUNK_W   = 64;
  localparam int unsigned CHUNK_SEL = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_BYTES = 8'd1;

  // Reset values of the configuration registers.
  localparam logic [BASE_W-1:0]       POOL_BASE_RST  = 48'd4096;
  localparam logic [SLOT_BYTES_W-1:0] SLOT_BYTES_RST = 13'd64;

  // Request command codes.
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // capture the request beat
    logic scan_step;  // examine one bitmap chunk
    logic commit;     // update the bitmap and start the address product
    logic load_out;   // move the result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_scan;  // the incoming request must search for a free slot
    logic hit;        // the current chunk holds a free slot
    logic last_chunk; // the current chunk is the final one
    logic out_free;   // the output register can take a result
  } dp_status_t;

endpackage

>>> rtl/core/spa_if.sv
// ----------------------------------------------------------------------------
// Slot pool allocator channels
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------

// Request channel: one beat per allocate or release.
interface spa_req_if;
  logic                              valid;
  logic                              ready;
  logic                              cmd;
  logic [spa_pkg::SLOT_IDX_W-1:0]    slot_index;

  modport source (output valid, output cmd, output slot_index, input ready);
  modport sink   (input valid, input cmd, input slot_index, output ready);
endinterface

// Result channel: one beat per request.
interface spa_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [spa_pkg::STATUS_W-1:0]      status;
  logic [spa_pkg::SLOT_IDX_W-1:0]    granted_slot;
  logic [spa_pkg::ADDR_W-1:0]        slot_address;
  logic                              pool_active;

  modport source (output valid, output status, output granted_slot,
                  output slot_address, output pool_active, input ready);
  modport sink   (input valid, input status, input granted_slot,
                  input slot_address, input pool_active, output ready);
endinterface

// Configuration write channel.
interface spa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [spa_pkg::CFG_IDX_W-1:0]     index;
  logic [spa_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/spa_ctrl.sv
// ----------------------------------------------------------------------------
// Slot pool allocator controller
// Sequences capture, bitmap scan, commit and result write for one request.
// ----------------------------------------------------------------------------
module spa_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  req_valid_i,
  output logic                  req_ready_o,
  input  spa_pkg::dp_status_t   status_i,
  output spa_pkg::ctrl_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_COMMIT = 4'b0100,
    S_WRITE  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // Next state and datapath commands.
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    req_ready_o      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.need_scan ? S_SCAN : S_COMMIT;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (status_i.hit || status_i.last_chunk) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = S_WRITE;
      end
      S_WRITE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> rtl/core/spa_datapath.sv
// ----------------------------------------------------------------------------
// Slot pool allocator datapath
// Holds the used bitmap, pool state, configuration and the result register.
// ----------------------------------------------------------------------------
module spa_datapath #(
  parameter int unsigned SLOTS = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              req_cmd_i,
  input  logic [spa_pkg::SLOT_IDX_W-1:0]    req_slot_index_i,
  input  spa_pkg::ctrl_cmd_t                cmd_i,
  output spa_pkg::dp_status_t               status_o,
  spa_rsp_if.source                         rsp,
  spa_cfg_if.sink                           cfg
);

  localparam int unsigned SW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNTW   = $clog2(SLOTS + 1);
  localparam int unsigned NCHUNK = (SLOTS + spa_pkg::CHUNK_W - 1) / spa_pkg::CHUNK_W;
  localparam int unsigned CW     = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int unsigned PADW   = NCHUNK * spa_pkg::CHUNK_W - SLOTS;
  localparam int unsigned PRODW  = SW + spa_pkg::SLOT_BYTES_W;

  // Configuration registers.
  logic [spa_pkg::BASE_W-1:0]       pool_base_q;
  logic [spa_pkg::SLOT_BYTES_W-1:0] slot_bytes_q;

  // Pool state.
  logic [SLOTS-1:0] used_q, used_d;
  logic [CNTW-1:0]  cnt_q, cnt_d;
  logic             active_q, active_d;

  // Request context.
  logic             cmd_q;
  logic             in_range_q;
  logic             found_q;
  logic [SW-1:0]    slot_q;
  logic [CW-1:0]    chunk_q;

  // Commit results.
  logic [PRODW-1:0]                 product_q;
  spa_pkg::status_e                 res_status_q;
  logic [spa_pkg::SLOT_IDX_W-1:0]   res_granted_q;
  logic                             res_valid_addr_q;

  // Output register.
  logic                             out_valid_q;
  spa_pkg::status_e                 out_status_q;
  logic [spa_pkg::SLOT_IDX_W-1:0]   out_granted_q;
  logic [spa_pkg::ADDR_W-1:0]       out_addr_q;
  logic                             out_active_q;

  // Decode of the incoming slot index.
  logic          in_range;
  logic [8:0]    idx_ext;
  logic [SW-1:0] idx_slot;

  assign idx_ext  = 9'(req_slot_index_i);
  assign idx_slot = idx_ext[SW-1:0];
  assign in_range = !req_slot_index_i[spa_pkg::SLOT_IDX_W-1] &&
                    (32'(req_slot_index_i[spa_pkg::SLOT_IDX_W-2:0]) < SLOTS);

  // Bitmap padded with used bits up to a whole number of chunks.
  logic [NCHUNK*spa_pkg::CHUNK_W-1:0] padded;

  if (PADW > 0) begin : g_pad
    assign padded = {{PADW{1'b1}}, used_q};
  end else begin : g_nopad
    assign padded = used_q;
  end

  // Priority encoder for the lowest free slot in the current chunk.
  logic [spa_pkg::CHUNK_W-1:0]   free_bits;
  logic [spa_pkg::CHUNK_SEL-1:0] enc;
  logic                          hit;
  logic [8:0]                    scan_ext;

  assign free_bits = ~padded[chunk_q*spa_pkg::CHUNK_W +: spa_pkg::CHUNK_W];
  assign hit       = |free_bits;
  assign scan_ext  = 9'({chunk_q, enc});

  always_comb begin
    enc = '0;
    for (int i = spa_pkg::CHUNK_W - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        enc = spa_pkg::CHUNK_SEL'(i);
      end
    end
  end

  // Status toward the controller.
  always_comb begin
    status_o.need_scan  = (req_cmd_i == spa_pkg::CMD_ALLOC) && !(in_range && active_q);
    status_o.hit        = hit;
    status_o.last_chunk = (chunk_q == CW'(NCHUNK - 1));
    status_o.out_free   = !out_valid_q || rsp.ready;
  end

  // Bitmap, count and active flag update at commit.
  logic          old_bit;
  logic [8:0]    slot_ext;

  assign old_bit  = used_q[slot_q];
  assign slot_ext = 9'(slot_q);

  always_comb begin
    used_d   = used_q;
    cnt_d    = cnt_q;
    active_d = active_q;
    if (cmd_q == spa_pkg::CMD_ALLOC) begin
      active_d = 1'b1;
      if (found_q) begin
        used_d[slot_q] = 1'b1;
        cnt_d          = cnt_q + CNTW'(!old_bit);
      end
    end else if (in_range_q) begin
      used_d[slot_q] = 1'b0;
      cnt_d          = cnt_q - CNTW'(old_bit);
      if (active_q && (cnt_d == '0)) begin
        active_d = 1'b0;
      end
    end
  end

  // Configuration writes; writes to unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= spa_pkg::POOL_BASE_RST;
      slot_bytes_q <= spa_pkg::SLOT_BYTES_RST;
    end else if (cfg.valid) begin
      if (cfg.index == spa_pkg::REG_POOL_BASE) begin
        pool_base_q <= cfg.data[spa_pkg::BASE_W-1:0];
      end else if (cfg.index == spa_pkg::REG_SLOT_BYTES) begin
        slot_bytes_q <= cfg.data[spa_pkg::SLOT_BYTES_W-1:0];
      end
    end
  end

  // Pool state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= '0;
      cnt_q    <= '0;
      active_q <= 1'b0;
    end else if (cmd_i.commit) begin
      used_q   <= used_d;
      cnt_q    <= cnt_d;
      active_q <= active_d;
    end
  end

  // Request capture and chunk scan.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chunk_q <= '0;
      found_q <= 1'b0;
    end else if (cmd_i.accept) begin
      chunk_q <= '0;
      found_q <= (req_cmd_i == spa_pkg::CMD_ALLOC) && in_range && active_q;
    end else if (cmd_i.scan_step) begin
      if (hit) begin
        found_q <= 1'b1;
      end else if (!status_o.last_chunk) begin
        chunk_q <= chunk_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cmd_q      <= req_cmd_i;
      in_range_q <= in_range;
      slot_q     <= idx_slot;
    end else if (cmd_i.scan_step && hit) begin
      slot_q     <= scan_ext[SW-1:0];
    end
  end

  // Commit: address product and result fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      product_q        <= PRODW'(slot_q) * PRODW'(slot_bytes_q);
      res_valid_addr_q <= (cmd_q == spa_pkg::CMD_ALLOC) && found_q;
      if (cmd_q == spa_pkg::CMD_ALLOC) begin
        res_status_q  <= found_q ? spa_pkg::ST_OK : spa_pkg::ST_FULL;
        res_granted_q <= found_q ? slot_ext[spa_pkg::SLOT_IDX_W-1:0] : '1;
      end else begin
        res_status_q  <= in_range_q ? spa_pkg::ST_OK : spa_pkg::ST_IGNORED;
        res_granted_q <= '1;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q  <= res_status_q;
      out_granted_q <= res_granted_q;
      out_active_q  <= active_q;
      out_addr_q    <= res_valid_addr_q ?
                       (spa_pkg::ADDR_W'(pool_base_q) + spa_pkg::ADDR_W'(product_q)) :
                       '0;
    end
  end

  assign rsp.valid        = out_valid_q;
  assign rsp.status       = out_status_q;
  assign rsp.granted_slot = out_granted_q;
  assign rsp.slot_address = out_addr_q;
  assign rsp.pool_active  = out_active_q;

endmodule

>>> rtl/core/slot_pool_allocator_unit.sv
// Sequence: the request beat is captured, an allocation that must search then scans the
// bitmap one 64-bit chunk at a time until a free slot or the last chunk, the commit
// updates the bitmap and forms the address product, and the result is written once the
// output register is free; the next request is taken once the result has entered it.
// Reset (rst_ni low, asynchronous): bitmap cleared, pool inactive, pool_base 4096,
// slot_bytes 64, no result pending.
// ----------------------------------------------------------------------------
// Slot pool allocator
// First-free slot allocator over a used bitmap with slot address generation.
// ----------------------------------------------------------------------------
module slot_pool_allocator_unit #(
  parameter int unsigned SLOTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  spa_req_if.sink     req_i,
  spa_rsp_if.source   rsp_o,
  spa_cfg_if.sink     cfg_i
);

  spa_pkg::ctrl_cmd_t  ctrl_cmd;
  spa_pkg::dp_status_t dp_status;
  logic                req_ready;

  assign req_i.ready = req_ready;

  // Controller.
  spa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .status_i    (dp_status),
    .cmd_o       (ctrl_cmd)
  );

  // Datapath.
  spa_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .req_cmd_i        (req_i.cmd),
    .req_slot_index_i (req_i.slot_index),
    .cmd_i            (ctrl_cmd),
    .status_o         (dp_status),
    .rsp              (rsp_o),
    .cfg              (cfg_i)
  );

endmodule
